FILE: hdl/gha_pkg.sv
// shared types and codes for the generational handle allocator
package gha_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL_OBJ = 3'd1,
        ST_NO_SCENE = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_AGEN,
        S_CHECK,
        S_RESP
    } t_state;

endpackage

FILE: hdl/gha_req_if.sv
// command channel: valid/ready plus one command word
interface gha_req_if #(
    parameter int IDX_W        = 8,
    parameter int GEN_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
);
    import gha_pkg::*;

    logic                    valid;
    logic                    ready;
    t_cmd                    cmd;
    logic [IDX_W-1:0]        handle_index;
    logic [GEN_BITS-1:0]     handle_gen;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, cmd, handle_index, handle_gen, payload, input ready);
    modport sink   (input valid, cmd, handle_index, handle_gen, payload, output ready);
endinterface

FILE: hdl/gha_rsp_if.sv
// response channel: valid/ready plus one result word
interface gha_rsp_if #(
    parameter int IDX_W        = 8,
    parameter int GEN_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
);
    import gha_pkg::*;

    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [IDX_W-1:0]        out_index;
    logic [GEN_BITS-1:0]     out_gen;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    is_valid;

    modport source (output valid, status, out_index, out_gen, out_payload, is_valid,
                    input ready);
    modport sink   (input valid, status, out_index, out_gen, out_payload, is_valid,
                    output ready);
endinterface

FILE: hdl/generational_handle_allocator.sv
// generational handle allocator: slot table and free stack in synchronous memories
//
//   channel   dir  handshake          word
//   i_req     in   valid/ready        cmd, handle_index, handle_gen, payload
//   o_rsp     out  valid/ready        status, out_index, out_gen, out_payload, is_valid
//   i_cfg     in   write enable only  scene_bound
//
// one command at a time: clear, errors, fresh allocate go to S_RESP; free and lookup
// via S_CHECK (one slot table read), a free stack allocate via S_POP and S_AGEN (stack
// read, then slot table read). the result sits in an output register, so a stalled
// o_rsp holds the last result while the next command runs up to its response step.
// reset (synchronous, active low) clears the counters and scene_bound; the memories
// need no clearing since only slots below the fresh mark are ever read.
module generational_handle_allocator #(
    parameter int SLOTS        = 256,
    parameter int GEN_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata,
    gha_req_if.sink   i_req,
    gha_rsp_if.source o_rsp
);
    import gha_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic                    live;
        logic [GEN_BITS-1:0]     gen;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_slot;

    // memories
    t_slot            r_tbl [SLOTS];
    logic [IDX_W-1:0] r_fs  [SLOTS];
    t_slot            r_tbl_rdata;
    logic [IDX_W-1:0] r_fs_rdata;

    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    t_slot            tbl_wdata;
    logic [IDX_W-1:0] tbl_raddr;
    logic             fs_we;
    logic [IDX_W-1:0] fs_waddr;
    logic [IDX_W-1:0] fs_wdata;
    logic [IDX_W-1:0] fs_raddr;

    // control and command registers
    t_state                  r_state, n_state;
    logic                    r_scene;
    logic [CNT_W-1:0]        r_free_cnt, n_free_cnt;
    logic [CNT_W-1:0]        r_fresh, n_fresh;
    t_cmd                    r_cmd;
    logic [IDX_W-1:0]        r_idx;
    logic [GEN_BITS-1:0]     r_gen;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [IDX_W-1:0]        r_slot, n_slot;

    // pending result
    t_status                 r_res_status, n_res_status;
    logic [IDX_W-1:0]        r_res_idx, n_res_idx;
    logic [GEN_BITS-1:0]     r_res_gen, n_res_gen;
    logic [PAYLOAD_BITS-1:0] r_res_pay, n_res_pay;
    logic                    r_res_valid, n_res_valid;

    // output register
    logic                    r_o_valid;
    t_status                 r_o_status;
    logic [IDX_W-1:0]        r_o_idx;
    logic [GEN_BITS-1:0]     r_o_gen;
    logic [PAYLOAD_BITS-1:0] r_o_pay;
    logic                    r_o_is_valid;

    logic                in_acc;
    logic                out_free;
    logic                stack_nonempty;
    logic                fresh_room;
    logic                handle_bad;
    logic                chk_ok;
    logic [CNT_W-1:0]    cnt_m1;
    logic [GEN_BITS-1:0] next_gen;

    assign i_req.ready    = (r_state == S_IDLE);
    assign in_acc         = i_req.valid && i_req.ready;
    assign out_free       = !r_o_valid || o_rsp.ready;
    assign stack_nonempty = (r_free_cnt != '0);
    assign fresh_room     = (r_fresh != CNT_W'(SLOTS));
    assign cnt_m1         = r_free_cnt - CNT_W'(1);
    assign handle_bad     = (i_req.handle_gen == '0)
                         || (CNT_W'(i_req.handle_index) >= r_fresh);
    assign chk_ok         = r_tbl_rdata.live && (r_tbl_rdata.gen == r_gen);
    // generation wraps from its maximum to 1
    assign next_gen       = (r_tbl_rdata.gen == '1) ? GEN_BITS'(1)
                                                    : r_tbl_rdata.gen + GEN_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rdata <= r_tbl[tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fs[fs_waddr] <= fs_wdata;
        end
        r_fs_rdata <= r_fs[fs_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_req.cmd) inside
                        CMD_ALLOC: begin
                            if (i_req.payload != '0 && r_scene && stack_nonempty) begin
                                n_state = S_POP;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        CMD_FREE, CMD_LOOKUP: begin
                            n_state = handle_bad ? S_RESP : S_CHECK;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_POP:   n_state = S_AGEN;
            S_AGEN:  n_state = S_RESP;
            S_CHECK: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_free_cnt   = r_free_cnt;
        n_fresh      = r_fresh;
        n_slot       = r_slot;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_gen    = r_res_gen;
        n_res_pay    = r_res_pay;
        n_res_valid  = r_res_valid;
        tbl_we       = 1'b0;
        tbl_waddr    = r_slot;
        tbl_wdata    = '0;
        tbl_raddr    = r_idx;
        fs_we        = 1'b0;
        fs_waddr     = r_free_cnt[IDX_W-1:0];
        fs_wdata     = r_idx;
        fs_raddr     = cnt_m1[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                tbl_raddr = i_req.handle_index;
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_idx    = '0;
                    n_res_gen    = '0;
                    n_res_pay    = '0;
                    n_res_valid  = 1'b0;
                    unique case (i_req.cmd) inside
                        CMD_ALLOC: begin
                            if (i_req.payload == '0) begin
                                n_res_status = ST_NULL_OBJ;
                            end else if (!r_scene) begin
                                n_res_status = ST_NO_SCENE;
                            end else if (stack_nonempty) begin
                                // top of stack is read this cycle
                                n_free_cnt = cnt_m1;
                            end else if (fresh_room) begin
                                tbl_we         = 1'b1;
                                tbl_waddr      = r_fresh[IDX_W-1:0];
                                tbl_wdata.live = 1'b1;
                                tbl_wdata.gen  = GEN_BITS'(1);
                                tbl_wdata.pay  = i_req.payload;
                                n_fresh        = r_fresh + CNT_W'(1);
                                n_res_idx      = r_fresh[IDX_W-1:0];
                                n_res_gen      = GEN_BITS'(1);
                            end else begin
                                n_res_status = ST_FULL;
                            end
                        end
                        CMD_FREE, CMD_LOOKUP: begin
                            if (handle_bad) begin
                                n_res_status = ST_INVALID;
                            end
                        end
                        default: begin
                            n_free_cnt = '0;
                            n_fresh    = '0;
                        end
                    endcase
                end
            end
            S_POP: begin
                tbl_raddr = r_fs_rdata;
                n_slot    = r_fs_rdata;
            end
            S_AGEN: begin
                tbl_we         = 1'b1;
                tbl_waddr      = r_slot;
                tbl_wdata.live = 1'b1;
                tbl_wdata.gen  = next_gen;
                tbl_wdata.pay  = r_pay;
                n_res_idx      = r_slot;
                n_res_gen      = next_gen;
            end
            S_CHECK: begin
                if (chk_ok) begin
                    n_res_valid = 1'b1;
                    if (r_cmd == CMD_FREE) begin
                        tbl_we         = 1'b1;
                        tbl_waddr      = r_idx;
                        tbl_wdata.live = 1'b0;
                        tbl_wdata.gen  = r_tbl_rdata.gen;
                        tbl_wdata.pay  = '0;
                        if (r_free_cnt != CNT_W'(SLOTS)) begin
                            fs_we      = 1'b1;
                            n_free_cnt = r_free_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_res_pay = r_tbl_rdata.pay;
                    end
                end else begin
                    n_res_status = ST_INVALID;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scene    <= 1'b0;
            r_free_cnt <= '0;
            r_fresh    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_cnt <= n_free_cnt;
            r_fresh    <= n_fresh;
            if (i_cfg_we) begin
                r_scene <= i_cfg_wdata;
            end
            if (r_state == S_RESP && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_req.cmd;
            r_idx <= i_req.handle_index;
            r_gen <= i_req.handle_gen;
            r_pay <= i_req.payload;
        end
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_gen    <= n_res_gen;
        r_res_pay    <= n_res_pay;
        r_res_valid  <= n_res_valid;
        if (r_state == S_RESP && out_free) begin
            r_o_status   <= r_res_status;
            r_o_idx      <= r_res_idx;
            r_o_gen      <= r_res_gen;
            r_o_pay      <= r_res_pay;
            r_o_is_valid <= r_res_valid;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.out_index   = r_o_idx;
    assign o_rsp.out_gen     = r_o_gen;
    assign o_rsp.out_payload = r_o_pay;
    assign o_rsp.is_valid    = r_o_is_valid;

endmodule

FILE: sim/gha_reply_checker.sv
// reply checker: watches both channels, predicts each reply word and compares it
module gha_reply_checker #(
    parameter int SLOTS = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    gha_req_if   i_req,
    gha_rsp_if   i_rsp,
    output int   o_errors,
    output int   o_pending
);
    import gha_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [7:0]  idx;
        logic [15:0] gen;
        logic [31:0] payload;
        logic        valid;
    } t_reply;

    // table as the block should hold it
    logic [15:0] slot_gen     [SLOTS];
    logic        slot_live    [SLOTS];
    logic [31:0] slot_payload [SLOTS];
    logic [7:0]  free_stack   [SLOTS];
    logic [8:0]  free_count;
    logic [8:0]  fresh_mark;
    logic        scene_bound;

    t_reply replies_due [$];

    function automatic bit handle_live(logic [7:0] hidx, logic [15:0] hgen);
        if (hgen == 16'd0) return 1'b0;
        if ({1'b0, hidx} >= fresh_mark) return 1'b0;
        return slot_live[hidx] && (slot_gen[hidx] == hgen);
    endfunction

    // updates the table copy and returns the reply the command must produce
    function automatic t_reply apply_command(t_cmd c, logic [7:0] hidx, logic [15:0] hgen,
                                             logic [31:0] pay);
        t_reply     r;
        logic [7:0] slot;
        logic [15:0] g;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_ALLOC: begin
                if (pay == 32'd0) begin
                    r.status = ST_NULL_OBJ;
                end else if (!scene_bound) begin
                    r.status = ST_NO_SCENE;
                end else if (free_count == 9'd0 && fresh_mark == SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    if (free_count != 9'd0) begin
                        free_count = free_count - 9'd1;
                        slot = free_stack[free_count[7:0]];
                    end else begin
                        slot = fresh_mark[7:0];
                        fresh_mark = fresh_mark + 9'd1;
                        slot_gen[slot] = 16'd0;
                    end
                    // generation skips 0 on wrap
                    g = (slot_gen[slot] == 16'hFFFF) ? 16'd1 : slot_gen[slot] + 16'd1;
                    slot_gen[slot] = g;
                    slot_live[slot] = 1'b1;
                    slot_payload[slot] = pay;
                    r.idx = slot;
                    r.gen = g;
                end
            end
            CMD_FREE: begin
                if (handle_live(hidx, hgen)) begin
                    slot_live[hidx] = 1'b0;
                    slot_payload[hidx] = 32'd0;
                    if (free_count < SLOTS) begin
                        free_stack[free_count[7:0]] = hidx;
                        free_count = free_count + 9'd1;
                    end
                    r.valid = 1'b1;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            CMD_LOOKUP: begin
                if (handle_live(hidx, hgen)) begin
                    r.payload = slot_payload[hidx];
                    r.valid = 1'b1;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            CMD_CLEAR: begin
                for (int k = 0; k < SLOTS; k++) slot_live[k] = 1'b0;
                free_count = 9'd0;
                fresh_mark = 9'd0;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            o_errors = 0;
            free_count = 9'd0;
            fresh_mark = 9'd0;
            scene_bound = 1'b0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) scene_bound = i_cfg_wdata;
            // a reply leaving now belongs to an earlier command, so compare first
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.status, i_rsp.out_index, i_rsp.out_gen, i_rsp.out_payload,
                        i_rsp.is_valid};
                if (replies_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: reply word with nothing outstanding: status=%0d",
                             $time, got.status,
                             " index=%0d gen=%0d payload=%h valid=%0d",
                             got.idx, got.gen, got.payload, got.valid);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.idx !== want.idx ||
                        got.gen !== want.gen || got.payload !== want.payload ||
                        got.valid !== want.valid) begin
                        o_errors++;
                        $display("%0t: reply mismatch, expected status=%0d",
                                 $time, want.status,
                                 " index=%0d gen=%0d payload=%h valid=%0d,",
                                 want.idx, want.gen, want.payload, want.valid,
                                 " actual status=%0d index=%0d gen=%0d",
                                 got.status, got.idx, got.gen,
                                 " payload=%h valid=%0d", got.payload, got.valid);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = apply_command(i_req.cmd, i_req.handle_index, i_req.handle_gen,
                                     i_req.payload);
                replies_due.insert(replies_due.size(), want);
            end
        end
        o_pending = replies_due.size();
    end

endmodule

FILE: sim/generational_handle_allocator_tb.sv
// testbench top: command stimulus, reply stalls and final verdict
module generational_handle_allocator_tb;
    import gha_pkg::*;

    localparam int SLOTS = 256;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   errors;
    int   pending;

    gha_req_if req_ch ();
    gha_rsp_if rsp_ch ();

    generational_handle_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    gha_reply_checker #(.SLOTS(SLOTS)) reply_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // handles seen in allocate replies, {index, generation}
    logic [23:0] handle_pool [$];
    int  burst_left;
    bit  steady_tx;
    bit  steady_rx;
    int  hold_ask;
    int  hold_seen;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
            !rsp_ch.is_valid && rsp_ch.out_gen != 16'd0) begin
            handle_pool.insert(handle_pool.size(), {rsp_ch.out_index, rsp_ch.out_gen});
            if (handle_pool.size() > 300) void'(handle_pool.pop_front());
        end
    end

    // reply side: stall pattern of its own, plus a long hold when asked
    initial begin
        int mode;
        int left;
        rsp_ch.ready = 1'b0;
        hold_seen = 0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_ask != hold_seen) begin
                rsp_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_seen = hold_ask;
            end else if (steady_rx) begin
                rsp_ch.ready = 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0: rsp_ch.ready = 1'b1;
                    1: rsp_ch.ready = 1'($urandom_range(0, 1));
                    2: rsp_ch.ready = ($urandom_range(0, 4) == 0);
                    default: rsp_ch.ready = ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_cmd(input t_cmd c, input logic [7:0] hidx, input logic [15:0] hgen,
                            input logic [31:0] pay);
        int gap;
        if (burst_left <= 0 && !steady_tx) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap > 0) begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        req_ch.valid = 1'b1;
        req_ch.cmd = c;
        req_ch.handle_index = hidx;
        req_ch.handle_gen = hgen;
        req_ch.payload = pay;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_scene(input logic v);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] random_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 9) return 32'hFFFF_FFFF;
        if (r < 12) return 32'd1;
        return $urandom;
    endfunction

    // mostly handles from earlier replies, some stale, null-generation or junk ones
    task automatic pick_handle(input bit take, output logic [7:0] hidx,
                               output logic [15:0] hgen);
        int k;
        int r;
        r = $urandom_range(0, 9);
        hidx = 8'($urandom_range(0, 255));
        hgen = 16'($urandom_range(0, 65535));
        if (handle_pool.size() != 0 && r < 8) begin
            k = $urandom_range(0, handle_pool.size() - 1);
            {hidx, hgen} = handle_pool[k];
            if (take && $urandom_range(0, 6) != 0) handle_pool.delete(k);
        end else if (r == 8) begin
            if ($urandom_range(0, 1)) hgen = 16'd0;
        end else if (handle_pool.size() != 0) begin
            k = $urandom_range(0, handle_pool.size() - 1);
            {hidx, hgen} = handle_pool[k];
            hgen = hgen + 16'd1;
        end
    endtask

    task automatic random_cmd(input int alloc_w, input int free_w, input int clear_w);
        int r;
        logic [7:0]  hidx;
        logic [15:0] hgen;
        r = $urandom_range(0, 99);
        if (r < alloc_w) begin
            send_cmd(CMD_ALLOC, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     random_payload());
        end else if (r < alloc_w + free_w) begin
            pick_handle(1'b1, hidx, hgen);
            send_cmd(CMD_FREE, hidx, hgen, $urandom);
        end else if (r < 100 - clear_w) begin
            pick_handle(1'b0, hidx, hgen);
            send_cmd(CMD_LOOKUP, hidx, hgen, $urandom);
        end else begin
            handle_pool.delete();
            send_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     $urandom);
        end
    endtask

    initial begin
        logic [15:0] g;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.handle_index = '0;
        req_ch.handle_gen = '0;
        req_ch.payload = '0;
        burst_left = 0;
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        hold_ask = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // no scene bound after reset; null payload outranks the missing scene
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'd1);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd0, 16'd1, 32'd0);
        send_cmd(CMD_FREE, 8'd0, 16'd0, 32'd0);
        wait_drained();
        write_scene(1'b1);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_ALLOC, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'd1);
        send_cmd(CMD_LOOKUP, 8'd0, 16'd1, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd0, 16'd2, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd2, 16'd1, 32'd0);
        send_cmd(CMD_FREE, 8'd1, 16'd1, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd1, 16'd1, 32'd0);
        send_cmd(CMD_FREE, 8'd1, 16'd1, 32'd0);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'h5A5A_A5A5);
        // two frees, then allocations come back in reverse order
        send_cmd(CMD_FREE, 8'd0, 16'd1, 32'd0);
        send_cmd(CMD_FREE, 8'd1, 16'd2, 32'd0);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'h0000_1234);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'h8000_0000);
        send_cmd(CMD_CLEAR, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_LOOKUP, 8'd0, 16'd2, 32'd0);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'h7FFF_FFFF);
        send_cmd(CMD_LOOKUP, 8'hFF, 16'hFFFF, 32'd0);
        wait_drained();
        handle_pool.delete();

        // mixed traffic, with a long reply stall halfway while words keep coming
        for (int n = 0; n < 200; n++) begin
            if (n == 100) begin
                hold_ask++;
                burst_left = 40;
            end
            random_cmd(40, 25, 2);
        end
        wait_drained();

        // fill the table until it reports full
        send_cmd(CMD_CLEAR, 8'd0, 16'd0, 32'd0);
        handle_pool.delete();
        for (int n = 0; n < 300; n++) random_cmd(95, 0, 0);
        wait_drained();

        // scene dropped on a full table: the missing scene outranks full
        write_scene(1'b0);
        for (int n = 0; n < 60; n++) random_cmd(40, 25, 1);
        wait_drained();

        write_scene(1'b1);
        for (int n = 0; n < 220; n++) random_cmd(45, 25, 2);
        wait_drained();

        // one slot freed and taken again back to back with no stalls
        steady_tx = 1'b1;
        steady_rx = 1'b1;
        send_cmd(CMD_CLEAR, 8'd0, 16'd0, 32'd0);
        send_cmd(CMD_ALLOC, 8'd0, 16'd0, 32'hC0DE_0001);
        g = 16'd1;
        for (int n = 0; n < 16; n++) begin
            send_cmd(CMD_FREE, 8'd0, g, 32'd0);
            send_cmd(CMD_ALLOC, 8'd0, 16'd0, $urandom | 32'd1);
            g = g + 16'd1;
            send_cmd(CMD_LOOKUP, 8'd0, g, 32'd0);
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;

        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
